@@ rtl/apiir_pkg.sv @@
// Shared types and constants for the all-pole recursive filter.
`default_nettype none

package apiir_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_ORDER_DEF    = 32;
    localparam int SAMPLE_WIDTH_DEF = 24;

    // Register field widths
    localparam int ORDER_W = 6;
    localparam int BLEN_W  = 16;

    // Accumulator width; it saturates at +/- 2^62
    localparam int ACC_W = 64;

    // Configuration channel
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic hist_clear;  // clear the output history
        logic coef_wr;     // store the input value as a coefficient
        logic start;       // load the accumulator with the input sample
        logic tap_vld;     // read one tap into the multiply pipeline
        logic finish;      // round, saturate, load the output, shift history
        logic last;        // block end flag for the result being finished
    } dp_cmd_t;

endpackage

`default_nettype wire

@@ rtl/apiir_ctrl.sv @@
// Controller: phase tracking, configuration registers and the per-sample sequencer.
`default_nettype none

module apiir_ctrl
    import apiir_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int CNT_W     = $clog2(MAX_ORDER + 1),
    parameter int ADDR_W    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output dp_cmd_t                    cmd,
    output logic [ADDR_W-1:0]          addr
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [ORDER_W-1:0]  order_reg, order_next;
    logic [BLEN_W-1:0]   blen_reg, blen_next;
    logic [CNT_W-1:0]    load_cnt_reg, load_cnt_next;
    logic [BLEN_W-1:0]   smp_cnt_reg, smp_cnt_next;
    logic                phase_reg, phase_next;
    logic [CNT_W-1:0]    tap_reg, tap_next;
    logic                drain_reg, drain_next;
    logic                last_reg, last_next;
    logic                out_vld_reg, out_vld_next;

    logic [CNT_W-1:0]    order_eff;
    logic [BLEN_W:0]     blen_eff;
    logic [BLEN_W:0]     smp_inc;
    logic [CNT_W-1:0]    load_inc;
    logic                in_xact;

    // Clamp order into 1..MAX_ORDER and block length to at least one
    always_comb begin
        if (order_reg == '0) begin
            order_eff = CNT_W'(1);
        end else if (32'(order_reg) > 32'(MAX_ORDER)) begin
            order_eff = CNT_W'(MAX_ORDER);
        end else begin
            order_eff = CNT_W'(order_reg);
        end
        blen_eff = (blen_reg == '0) ? (BLEN_W + 1)'(1) : {1'b0, blen_reg};
    end

    assign smp_inc  = {1'b0, smp_cnt_reg} + (BLEN_W + 1)'(1);
    assign load_inc = load_cnt_reg + CNT_W'(1);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign in_xact   = s_tvalid && s_tready;

    // Sequence one input transaction and update phase counters
    always_comb begin
        state_next    = state_reg;
        order_next    = order_reg;
        blen_next     = blen_reg;
        load_cnt_next = load_cnt_reg;
        smp_cnt_next  = smp_cnt_reg;
        phase_next    = phase_reg;
        tap_next      = tap_reg;
        drain_next    = drain_reg;
        last_next     = last_reg;
        out_vld_next  = out_vld_reg;
        cmd           = '0;
        cmd.last      = last_reg;
        addr          = load_cnt_reg[ADDR_W-1:0];

        // Drop the result once the downstream side takes it
        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                addr = load_cnt_reg[ADDR_W-1:0];
                if (in_xact) begin
                    if (!phase_reg) begin
                        cmd.coef_wr = 1'b1;
                        if (load_inc >= order_eff) begin
                            load_cnt_next = '0;
                            smp_cnt_next  = '0;
                            phase_next    = 1'b1;
                        end else begin
                            load_cnt_next = load_inc;
                        end
                    end else begin
                        cmd.start  = 1'b1;
                        tap_next   = '0;
                        state_next = ST_MAC;
                        if (smp_inc >= blen_eff) begin
                            last_next     = 1'b1;
                            smp_cnt_next  = '0;
                            load_cnt_next = '0;
                            phase_next    = 1'b0;
                        end else begin
                            last_next    = 1'b0;
                            smp_cnt_next = smp_inc[BLEN_W-1:0];
                        end
                    end
                end
            end
            ST_MAC: begin
                addr        = tap_reg[ADDR_W-1:0];
                cmd.tap_vld = 1'b1;
                if (tap_reg + CNT_W'(1) == order_eff) begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end else begin
                    tap_next = tap_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                // Wait for the read and multiply stages to empty
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_vld_reg || m_tready) begin
                    cmd.finish   = 1'b1;
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Apply configuration writes; the user must send them only while idle, the block does not enforce it
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FILTER_ORDER: begin
                    order_next     = cfg_data[ORDER_W-1:0];
                    cmd.hist_clear = 1'b1;
                    load_cnt_next  = '0;
                    smp_cnt_next   = '0;
                    phase_next     = 1'b0;
                end
                REG_BLOCK_LENGTH: begin
                    blen_next = cfg_data[BLEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Hold controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            order_reg    <= ORDER_W'(16);
            blen_reg     <= BLEN_W'(128);
            load_cnt_reg <= '0;
            smp_cnt_reg  <= '0;
            phase_reg    <= 1'b0;
            tap_reg      <= '0;
            drain_reg    <= 1'b0;
            last_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            order_reg    <= order_next;
            blen_reg     <= blen_next;
            load_cnt_reg <= load_cnt_next;
            smp_cnt_reg  <= smp_cnt_next;
            phase_reg    <= phase_next;
            tap_reg      <= tap_next;
            drain_reg    <= drain_next;
            last_reg     <= last_next;
            out_vld_reg  <= out_vld_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/apiir_dp.sv @@
// Datapath: coefficient memory, output history, shared multiply-accumulate and output rounding.
`default_nettype none

module apiir_dp
    import apiir_pkg::*;
#(
    parameter int MAX_ORDER    = MAX_ORDER_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int ADDR_W       = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire dp_cmd_t                        cmd,
    input  wire logic [ADDR_W-1:0]              addr,
    input  wire logic signed [SAMPLE_WIDTH-1:0] in_value,
    output logic signed [SAMPLE_WIDTH-1:0]      y_out,
    output logic                                last_out,
    output logic                                sat_out
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int FRAC   = SAMPLE_WIDTH - 4;
    localparam int PROD_W = 2 * SAMPLE_WIDTH;

    localparam logic signed [ACC_W:0] ACC_MAX  = (ACC_W + 1)'(65'sd4611686018427387904);
    localparam logic signed [ACC_W:0] ACC_MIN  = -ACC_MAX;
    localparam logic signed [ACC_W:0] HALF_LSB = (ACC_W + 1)'(1) <<< (FRAC - 1);
    localparam logic signed [ACC_W:0] Y_MAX    = ((ACC_W + 1)'(1) <<< (SW - 1)) - 1;
    localparam logic signed [ACC_W:0] Y_MIN    = -Y_MAX - 1;

    logic signed [SW-1:0]     coef_mem [MAX_ORDER];
    logic signed [SW-1:0]     hist_reg [MAX_ORDER];
    logic signed [SW-1:0]     coef_q_reg;
    logic signed [SW-1:0]     hist_q_reg;
    logic                     v1_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     v2_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W:0]    rnd_sum;
    logic signed [ACC_W:0]    y_full;
    logic signed [SW-1:0]     y_sat;
    logic                     sat_flag;
    logic signed [SW-1:0]     y_reg;
    logic                     last_reg;
    logic                     sat_reg;

    // Store coefficients and read one tap per cycle
    always_ff @(posedge aclk) begin
        if (cmd.coef_wr) begin
            coef_mem[addr] <= in_value;
        end
        if (cmd.tap_vld) begin
            coef_q_reg <= coef_mem[addr];
            hist_q_reg <= hist_reg[addr];
        end
    end

    assign prod_next = PROD_W'(coef_q_reg) * PROD_W'(hist_q_reg);

    // Multiply the tap read in the previous cycle
    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            prod_reg <= prod_next;
        end
    end

    // Add with saturation at +/- 2^62
    always_comb begin
        acc_sum = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(prod_reg);
        if (acc_sum > ACC_MAX) begin
            acc_next = ACC_W'(ACC_MAX);
        end else if (acc_sum < ACC_MIN) begin
            acc_next = ACC_W'(ACC_MIN);
        end else begin
            acc_next = ACC_W'(acc_sum);
        end
    end

    // Load the accumulator with the aligned sample, then accumulate products
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            acc_reg <= ACC_W'(in_value) <<< FRAC;
        end else if (v2_reg) begin
            acc_reg <= acc_next;
        end
    end

    // Track pipeline occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.tap_vld;
            v2_reg <= v1_reg;
        end
    end

    // Round half up to the output fraction, then clip to the sample range
    always_comb begin
        rnd_sum = (ACC_W + 1)'(acc_reg) + HALF_LSB;
        y_full  = rnd_sum >>> FRAC;
        if (y_full > Y_MAX) begin
            y_sat    = SW'(Y_MAX);
            sat_flag = 1'b1;
        end else if (y_full < Y_MIN) begin
            y_sat    = SW'(Y_MIN);
            sat_flag = 1'b1;
        end else begin
            y_sat    = SW'(y_full);
            sat_flag = 1'b0;
        end
    end

    // Shift the new output into the history
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.hist_clear) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (cmd.finish) begin
            for (int i = MAX_ORDER - 1; i > 0; i--) begin
                hist_reg[i] <= hist_reg[i-1];
            end
            hist_reg[0] <= y_sat;
        end
    end

    // Hold the result for the output channel
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            y_reg    <= y_sat;
            last_reg <= cmd.last;
            sat_reg  <= sat_flag;
        end
    end

    assign y_out    = y_reg;
    assign last_out = last_reg;
    assign sat_out  = sat_reg;

endmodule

`default_nettype wire

@@ rtl/all_pole_iir_block_coefficients_core.sv @@
// Top level: all-pole recursive filter with per-block coefficient reload.
// A coefficient transaction is taken while idle and gives no result.
// A sample transaction is taken only while idle; the controller then steps through the MAC,
// drain and done states, and the next transaction waits until the result is offered, as the
// one shared multiply-accumulate visits each tap in turn.
// Reset is synchronous, active low: it clears the control state and the output history;
// the coefficient memory is not cleared and holds whatever was last loaded.
`default_nettype none

module all_pole_iir_block_coefficients_core
    import apiir_pkg::*;
#(
    parameter int MAX_ORDER    = MAX_ORDER_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata: [SAMPLE_WIDTH-1:0] value, zero padded to whole bytes
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // m_tdata: [SAMPLE_WIDTH-1:0] filtered_sample, zero padded to whole bytes
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_tdata,
    output logic                                   m_tlast,
    // m_tuser: [0] saturated
    output logic [0:0]                             m_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]              cfg_index,
    input  wire logic [CFG_DATA_W-1:0]             cfg_data
);

    localparam int CNT_W  = $clog2(MAX_ORDER + 1);
    localparam int ADDR_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    dp_cmd_t                  cmd;
    logic [ADDR_W-1:0]        addr;
    logic signed [SAMPLE_WIDTH-1:0] y_out;
    logic                     last_out;
    logic                     sat_out;

    apiir_ctrl #(
        .MAX_ORDER (MAX_ORDER),
        .CNT_W     (CNT_W),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .addr      (addr)
    );

    apiir_dp #(
        .MAX_ORDER    (MAX_ORDER),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ADDR_W       (ADDR_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .addr     (addr),
        .in_value (s_tdata[SAMPLE_WIDTH-1:0]),
        .y_out    (y_out),
        .last_out (last_out),
        .sat_out  (sat_out)
    );

    // Pack the result fields
    always_comb begin
        m_tdata                 = '0;
        m_tdata[SAMPLE_WIDTH-1:0] = y_out;
    end

    assign m_tlast    = last_out;
    assign m_tuser[0] = sat_out;

endmodule

`default_nettype wire

@@ rtl/apiir_checker.sv @@
// Port-level assertions for the filter top level and their bind.
`default_nettype none

module apiir_checker
    import apiir_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
    input wire logic [0:0]                        m_tuser,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready
);

    localparam logic [SAMPLE_WIDTH-1:0] Y_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] Y_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // A pending result stays offered until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before it was taken");

    // A result is withdrawn only after a completed output transaction
    a_out_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result withdrawn without a transaction");

    // A new result appears only after the sequencer was busy
    a_out_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a filter pass");

    // A clipped result carries a range limit
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[SAMPLE_WIDTH-1:0] == Y_POS) || (m_tdata[SAMPLE_WIDTH-1:0] == Y_NEG))
        else $error("saturated flag set on an unclipped value");

    // Configuration writes are never refused
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind all_pole_iir_block_coefficients_core apiir_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_apiir_checker (.*);

`default_nettype wire

@@ bench/tb_all_pole_iir_block_coefficients_core.sv @@
// Self-checking testbench for the all-pole recursive filter with per-block coefficient reload.

module tb_all_pole_iir_block_coefficients_core
    import apiir_pkg::*;
;

    localparam int W    = SAMPLE_WIDTH_DEF;
    localparam int DW   = ((W + 7) / 8) * 8;
    localparam int FRAC = W - 4;
    localparam int TAPS = MAX_ORDER_DEF;

    localparam longint ACC_CAP = longint'(1) << 62;
    localparam longint Y_MAX   = (longint'(1) << (W - 1)) - 1;
    localparam longint Y_MIN   = -Y_MAX - 1;

    localparam int ORDER_AT_RESET = 16;
    localparam int BLEN_AT_RESET  = 128;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int RANDOM_ITEMS  = 1750;
    localparam int QUIET_FROM    = 1450;
    localparam int SETTLE_CYCLES = TAPS + 8;
    localparam int CYCLE_LIMIT   = 1000000;

    // Coefficient styles for the random part
    typedef enum int {COEF_STABLE, COEF_WIDE, COEF_NOISE} coef_style_t;

    typedef struct packed {
        logic [W-1:0] sample;
        logic         block_end;
        logic         clipped;
    } filter_out_t;

    // Tracks filter state and holds the outputs still owed by the block
    class allpole_tracker;
        logic signed [W-1:0] coefs [TAPS];
        logic signed [W-1:0] history [TAPS];
        int unsigned         coef_fill;
        int unsigned         samples_done;
        bit                  in_samples;
        logic [ORDER_W-1:0]  order_reg;
        logic [BLEN_W-1:0]   blen_reg;
        filter_out_t         owed_q[$];
        int unsigned         mismatches;
        int unsigned         outputs_checked;
        int unsigned         block_ends;
        int unsigned         clip_count;
        int unsigned         coefs_loaded;
        int unsigned         reg_writes;

        function new();
            foreach (coefs[i]) coefs[i] = '0;
            foreach (history[i]) history[i] = '0;
            coef_fill = 0;
            samples_done = 0;
            in_samples = 1'b0;
            order_reg = ORDER_W'(ORDER_AT_RESET);
            blen_reg = BLEN_W'(BLEN_AT_RESET);
            mismatches = 0;
            outputs_checked = 0;
            block_ends = 0;
            clip_count = 0;
            coefs_loaded = 0;
            reg_writes = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Apply one register write; an order write restarts the coefficient load
        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            if (idx == REG_FILTER_ORDER) begin
                order_reg = data[ORDER_W-1:0];
                foreach (history[i]) history[i] = '0;
                coef_fill = 0;
                samples_done = 0;
                in_samples = 1'b0;
            end else if (idx == REG_BLOCK_LENGTH) begin
                blen_reg = data[BLEN_W-1:0];
            end
        endfunction

        // Consume one input transaction: store a coefficient or filter a sample
        function void take_value(logic [W-1:0] raw);
            int          taps;
            int unsigned blen_eff;
            int          k;
            longint      acc;
            longint      y;
            filter_out_t r;

            taps = (order_reg == 0) ? 1 : (order_reg > TAPS) ? TAPS : int'(order_reg);
            blen_eff = (blen_reg == 0) ? 1 : blen_reg;

            if (!in_samples) begin
                if (coef_fill < TAPS) coefs[coef_fill] = raw;
                coef_fill++;
                coefs_loaded++;
                if (coef_fill >= taps) begin
                    coef_fill = 0;
                    samples_done = 0;
                    in_samples = 1'b1;
                end
                return;
            end

            // Accumulate with the sample aligned to the product fraction bits
            acc = longint'($signed(raw)) * (longint'(1) << FRAC);
            for (k = 0; k < taps; k++) begin
                acc = acc + longint'(coefs[k]) * longint'(history[k]);
                if (acc > ACC_CAP) acc = ACC_CAP;
                else if (acc < -ACC_CAP) acc = -ACC_CAP;
            end

            // Round half up, then clip to the sample range
            y = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
            r.clipped = 1'b0;
            if (y > Y_MAX) begin
                y = Y_MAX;
                r.clipped = 1'b1;
            end else if (y < Y_MIN) begin
                y = Y_MIN;
                r.clipped = 1'b1;
            end

            for (k = taps - 1; k >= 1; k--) history[k] = history[k - 1];
            history[0] = y[W-1:0];

            samples_done++;
            r.block_end = 1'b0;
            if (samples_done >= blen_eff) begin
                r.block_end = 1'b1;
                samples_done = 0;
                coef_fill = 0;
                in_samples = 1'b0;
            end
            r.sample = y[W-1:0];
            owed_q.push_back(r);
        endfunction

        // Compare one output transaction against the oldest owed output
        function void check_output(logic [W-1:0] data, logic block_end, logic clipped);
            filter_out_t want;

            if (owed_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected output, expected none, actual %0d last=%b sat=%b",
                         $time, $signed(data), block_end, clipped);
                return;
            end
            want = owed_q.pop_front();
            outputs_checked++;
            if (want.block_end) block_ends++;
            if (want.clipped) clip_count++;
            if (data !== want.sample) begin
                mismatches++;
                $display("%0t: filtered_sample expected %0d, actual %0d",
                         $time, $signed(want.sample), $signed(data));
            end
            if (block_end !== want.block_end) begin
                mismatches++;
                $display("%0t: block_end expected %b, actual %b", $time, want.block_end, block_end);
            end
            if (clipped !== want.clipped) begin
                mismatches++;
                $display("%0t: saturated expected %b, actual %b", $time, want.clipped, clipped);
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DW-1:0]         s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DW-1:0]         m_tdata;
    logic                  m_tlast;
    logic [0:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    allpole_tracker book;
    bit             gaps_on   = 1'b1;
    bit             stalls_on = 1'b1;
    int             hold_left = 0;
    int unsigned    items_sent = 0;
    int unsigned    cycle_count = 0;

    all_pole_iir_block_coefficients_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Generate the clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Stall the result side in short random bursts
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            hold_left = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Observe every transaction at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) book.apply_register(cfg_index, cfg_data);
            if (m_tvalid && m_tready) book.check_output(m_tdata[W-1:0], m_tlast, m_tuser[0]);
            if (s_tvalid && s_tready) book.take_value(s_tdata[W-1:0]);
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d outputs still owed",
                     $time, cycle_count, book.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Send one input transaction, with an optional idle burst ahead of it
    task automatic send_value(input logic [31:0] word);
        int            gap;
        logic [DW-1:0] padded;

        padded = '0;
        padded[W-1:0] = word[W-1:0];
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= padded;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Write one register through the configuration channel
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Hold the input until every owed output has arrived; before a write, let
    // a coefficient transaction still in flight finish as well
    task automatic settle(input bit for_write);
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (book.pending() != 0) @(negedge aclk);
        if (for_write) repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int                    phase_no;
        int                    taps_eff;
        int unsigned           blen_eff;
        int unsigned           nsamp;
        int unsigned           cut;
        int                    nblocks;
        int                    pick;
        int                    lim;
        int                    v;
        int                    leftover;
        bit                    clean;
        coef_style_t           style;
        logic [CFG_DATA_W-1:0] odata;
        logic [CFG_DATA_W-1:0] bdata;

        book = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Extreme coefficients and samples; the second output clips
        write_reg(REG_FILTER_ORDER, 16'd2);
        write_reg(REG_BLOCK_LENGTH, 16'd3);
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h0001);
        send_value(32'h007FFFFF);
        send_value(32'h00800000);
        send_value(32'h007FFFFF);
        send_value(32'h00800000);
        send_value(32'h00000000);
        settle(1'b1);

        // Block length zero acts as one; half-LSB sums round upward
        write_reg(REG_FILTER_ORDER, 16'd1);
        write_reg(REG_BLOCK_LENGTH, 16'd0);
        send_value(32'h00080000);
        send_value(32'h00000003);
        send_value(32'h00080000);
        send_value(32'h00000000);
        send_value(32'h00F80000);
        send_value(32'h00000000);
        send_value(32'h00080000);
        send_value(32'h00000000);
        settle(1'b1);

        // Order zero acts as one
        write_reg(REG_FILTER_ORDER, 16'd0);
        send_value(32'h00100000);
        send_value(32'h00000005);
        settle(1'b1);

        // Shorten the block length mid-block; the next sample ends the block
        write_reg(REG_FILTER_ORDER, 16'd1);
        write_reg(REG_BLOCK_LENGTH, 16'd100);
        send_value(32'h00040000);
        repeat (4) send_value($urandom);
        settle(1'b1);
        write_reg(REG_BLOCK_LENGTH, 16'd2);
        send_value(32'h007FFFFF);
        send_value(32'h00800000);
        send_value(32'h00800000);
        settle(1'b1);

        // Random phases: mostly whole blocks, some cut short or noisy
        items_sent = 0;
        phase_no = 0;
        clean = 1'b0;
        while (items_sent < RANDOM_ITEMS) begin
            gaps_on = (items_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            stalls_on = (items_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            settle(1'b1);

            // Pick the order; the first phases force the extremes
            pick = $urandom_range(0, 19);
            case (phase_no)
                0: odata = 16'd32;
                1: odata = 16'hFFFF;
                2: odata = 16'hFFE0;
                default: begin
                    odata = CFG_DATA_W'($urandom);
                    if (pick == 0) odata[ORDER_W-1:0] = '0;
                    else if (pick == 1)
                        odata[ORDER_W-1:0] = ORDER_W'($urandom_range(TAPS + 1, 63));
                    else if (pick < 6) odata[ORDER_W-1:0] = ORDER_W'($urandom_range(9, TAPS));
                    else odata[ORDER_W-1:0] = ORDER_W'($urandom_range(1, 8));
                    if ($urandom_range(0, 3) != 0) odata[CFG_DATA_W-1:ORDER_W] = '0;
                end
            endcase
            if (!clean || phase_no < 3 || $urandom_range(0, 2) != 0) begin
                write_reg(REG_FILTER_ORDER, odata);
                taps_eff = (odata[ORDER_W-1:0] == 0) ? 1 :
                           (odata[ORDER_W-1:0] > TAPS) ? TAPS : int'(odata[ORDER_W-1:0]);
            end

            // Pick the block length; huge blocks are cut short
            cut = 1 << 30;
            nblocks = $urandom_range(1, 4);
            pick = $urandom_range(0, 9);
            case (phase_no)
                0: begin
                    bdata = 16'hFFFF;
                    cut = 40;
                    nblocks = 1;
                end
                1: bdata = 16'd20;
                2: bdata = 16'd3;
                default: begin
                    if (pick == 0) begin
                        bdata = '0;
                    end else if (pick == 1) begin
                        bdata = CFG_DATA_W'($urandom);
                        cut = 30;
                        nblocks = 1;
                    end else begin
                        bdata = CFG_DATA_W'($urandom_range(1, 24));
                    end
                end
            endcase
            write_reg(REG_BLOCK_LENGTH, bdata);
            blen_eff = (bdata == 0) ? 1 : bdata;
            nsamp = (blen_eff > cut) ? cut : blen_eff;

            pick = $urandom_range(0, 9);
            style = (pick < 6) ? COEF_STABLE : (pick < 8) ? COEF_WIDE : COEF_NOISE;

            repeat (nblocks) begin
                // Load the coefficient set
                repeat (taps_eff) begin
                    case (style)
                        COEF_STABLE: lim = (1 << FRAC) / (taps_eff + 1);
                        COEF_WIDE:   lim = 1 << (FRAC + 1);
                        default:     lim = 0;
                    endcase
                    if (style == COEF_NOISE) v = $urandom;
                    else v = int'($urandom_range(0, 2 * lim)) - lim;
                    send_value(v);
                end
                // Filter the samples, now and then holding until all results are back
                repeat (nsamp) begin
                    if ($urandom_range(0, 40) == 0) settle(1'b0);
                    if ($urandom_range(0, 9) < 3) v = int'($urandom_range(0, 8192)) - 4096;
                    else v = $urandom;
                    send_value(v);
                end
            end
            clean = (nsamp == blen_eff);
            phase_no++;
        end

        // Drain the remaining outputs
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        leftover = book.pending();
        if (leftover != 0) $display("%0t: %0d expected outputs never arrived", $time, leftover);

        $display("Run covered %0d filter outputs with %0d block ends and %0d clipped samples,",
                 book.outputs_checked, book.block_ends, book.clip_count);
        $display("over %0d coefficient loads, %0d register writes and %0d random phases.",
                 book.coefs_loaded, book.reg_writes, phase_no);
        if (book.mismatches == 0 && leftover == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
